>>> hdl/grw_pkg.sv
`timescale 1ns / 1ps
// Types, constants and helpers shared by the grid ray wall cast block.
// No dependencies.
package grw_pkg;

    localparam int COORD_W   = 24;  // Q8.16 coordinate width
    localparam int FRAC_W    = 16;  // fraction bits
    localparam int CFG_W     = 7;   // map size register width
    localparam int CELL_W    = 6;   // cell index field width
    localparam int EPS_LSB   = 1;   // backoff when stepping toward negative
    localparam int DELTA_W   = COORD_W + 1;
    localparam int NUM_W     = DELTA_W + FRAC_W;  // dividend width
    localparam int SLOPE_W   = 32;
    localparam int PS_W      = COORD_W + 2;
    localparam int OFS_W     = 18;  // snapped start minus origin
    localparam int PROD_W    = OFS_W + SLOPE_W;
    localparam int POS_W     = 48;  // running position width

    localparam logic [SLOPE_W-1:0] SLOPE_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic                      cmd;
        logic                      cast_axis;
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
        logic [CELL_W-1:0]         cell_col;
        logic [CELL_W-1:0]         cell_row;
        logic                      cell_is_wall;
    } in_word_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] hit_x;
        logic signed [COORD_W-1:0] hit_y;
        logic                      hit_wall;
        logic                      degenerate;
    } out_word_t;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic prep;
        logic div_step;
        logic slope_fix;
        logic mul;
        logic init;
        logic lookup;
        logic step;
        logic wall_set;
        logic out_load;
        logic wr_read;
        logic wr_write;
    } grw_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_write;
        logic wr_ok;
        logic degen;
        logic div_last;
        logic guard_end;
        logic in_map;
        logic wall_bit;
    } grw_stat_t;

    // Saturate a running position to a Q8.16 coordinate
    function automatic logic [COORD_W-1:0] sat24(input logic signed [POS_W-1:0] v);
        logic signed [POS_W-1:0] hi;
        logic signed [POS_W-1:0] lo;
        hi = POS_W'(8388607);
        lo = -POS_W'(8388608);
        if (v > hi)
            return hi[COORD_W-1:0];
        else if (v < lo)
            return lo[COORD_W-1:0];
        else
            return v[COORD_W-1:0];
    endfunction

endpackage

>>> hdl/grw_map_mem.sv
`timescale 1ns / 1ps
// Wall map store: one row of cells per word, registered read, per-row valid bits.
// Depends on nothing.
module grw_map_mem #(
    parameter int MAP_SIZE = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [$clog2(MAP_SIZE)-1:0] rd_addr,
    input  logic                        wr_en,
    input  logic [$clog2(MAP_SIZE)-1:0] wr_addr,
    input  logic [MAP_SIZE-1:0]         wr_data,
    output logic [MAP_SIZE-1:0]         rd_data
);

    logic [MAP_SIZE-1:0] mem [MAP_SIZE];
    logic [MAP_SIZE-1:0] row_vld_reg;
    logic [MAP_SIZE-1:0] rd_data_reg;
    logic                rd_vld_reg;

    // Row valid bits: a row never written reads as empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
                row_vld_reg[wr_addr] <= 1'b1;
            if (rd_en)
                rd_vld_reg <= row_vld_reg[rd_addr];
        end
    end

    // Storage array
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

>>> hdl/grw_datapath.sv
`timescale 1ns / 1ps
// Datapath: input word, slope divider, start point multiply, ray stepper, result word.
// Depends on grw_pkg and grw_map_mem.
module grw_datapath #(
    parameter int MAP_SIZE = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  grw_pkg::grw_cmd_t             cmd,
    output grw_pkg::grw_stat_t            stat,
    input  grw_pkg::in_word_t             in_word,
    input  logic [grw_pkg::CFG_W-1:0]     map_width,
    input  logic [grw_pkg::CFG_W-1:0]     map_height,
    output grw_pkg::out_word_t            out_word
);

    localparam int IDX_W   = $clog2(MAP_SIZE);
    localparam int GUARD_N = MAP_SIZE + 2;
    localparam int GUARD_W = $clog2(GUARD_N + 1);
    localparam int DCNT_W  = $clog2(grw_pkg::NUM_W);
    localparam int POS_W   = grw_pkg::POS_W;
    localparam int FRAC_W  = grw_pkg::FRAC_W;

    grw_pkg::in_word_t                      in_reg;
    logic                                   degen_reg;
    logic                                   up_reg;
    logic                                   neg_reg;
    logic [grw_pkg::DELTA_W-1:0]            den_reg;
    logic [grw_pkg::NUM_W-1:0]              num_reg;
    logic [grw_pkg::DELTA_W:0]              rem_reg;
    logic [DCNT_W-1:0]                      dcnt_reg;
    logic signed [grw_pkg::SLOPE_W-1:0]     slope_reg;
    logic signed [grw_pkg::PS_W-1:0]        ps_reg;
    logic signed [grw_pkg::OFS_W-1:0]       ofs_reg;
    logic signed [grw_pkg::PROD_W-1:0]      prod_reg;
    logic signed [POS_W-1:0]                s_reg;
    logic signed [POS_W-1:0]                c_reg;
    logic [GUARD_W-1:0]                     guard_reg;
    logic [IDX_W-1:0]                       ci_reg;
    logic                                   wall_reg;
    grw_pkg::out_word_t                     out_reg;

    // Prep: deltas and operand selection per axis
    logic signed [grw_pkg::DELTA_W-1:0] dx, dy, ds, dc;
    logic signed [grw_pkg::COORD_W-1:0] os, ts;
    logic signed [grw_pkg::PS_W-1:0]    fs, ps_new, ofs_full;
    logic [grw_pkg::DELTA_W-1:0]        ds_mag, dc_mag;

    always_comb
    begin
        dx = grw_pkg::DELTA_W'(in_reg.target_x) - grw_pkg::DELTA_W'(in_reg.origin_x);
        dy = grw_pkg::DELTA_W'(in_reg.target_y) - grw_pkg::DELTA_W'(in_reg.origin_y);
        ds = in_reg.cast_axis ? dy : dx;
        dc = in_reg.cast_axis ? dx : dy;
        os = in_reg.cast_axis ? in_reg.origin_y : in_reg.origin_x;
        ts = in_reg.cast_axis ? in_reg.target_y : in_reg.target_x;
        ds_mag = ds[grw_pkg::DELTA_W-1] ? grw_pkg::DELTA_W'(-ds) : grw_pkg::DELTA_W'(ds);
        dc_mag = dc[grw_pkg::DELTA_W-1] ? grw_pkg::DELTA_W'(-dc) : grw_pkg::DELTA_W'(dc);
        fs = grw_pkg::PS_W'(signed'({os[grw_pkg::COORD_W-1:FRAC_W], {FRAC_W{1'b0}}}));
        ps_new = (ts > os) ? fs + grw_pkg::PS_W'(1 << FRAC_W)
                           : fs - grw_pkg::PS_W'(grw_pkg::EPS_LSB);
        ofs_full = ps_new - grw_pkg::PS_W'(os);
    end

    // Divider step: one quotient bit per cycle
    logic [grw_pkg::DELTA_W:0] trial;
    logic                      qbit;
    always_comb
    begin
        trial = {rem_reg[grw_pkg::DELTA_W-1:0], num_reg[grw_pkg::NUM_W-1]};
        qbit  = trial >= {1'b0, den_reg};
    end

    // Slope saturation and sign
    logic [grw_pkg::SLOPE_W-1:0] mag_sat;
    always_comb
    begin
        mag_sat = (|num_reg[grw_pkg::NUM_W-1:grw_pkg::SLOPE_W-1])
                  ? grw_pkg::SLOPE_MAX
                  : {1'b0, num_reg[grw_pkg::SLOPE_W-2:0]};
    end

    // Start point: product / 1.0 truncated toward zero, plus other origin
    logic signed [grw_pkg::PROD_W-1:0] prod_adj;
    logic signed [grw_pkg::PROD_W-1:0] pq;
    logic signed [grw_pkg::COORD_W-1:0] oc;
    always_comb
    begin
        prod_adj = prod_reg + (prod_reg[grw_pkg::PROD_W-1]
                   ? grw_pkg::PROD_W'((1 << FRAC_W) - 1) : '0);
        pq = prod_adj >>> FRAC_W;
        oc = in_reg.cast_axis ? in_reg.origin_x : in_reg.origin_y;
    end

    // Map bounds check
    logic [grw_pkg::CFG_W-1:0] wlim, hlim;
    logic signed [POS_W-1:0]   px, py;
    logic                      in_x, in_y;
    logic [IDX_W-1:0]          ci, ri;

    function automatic logic inside_of(input logic signed [POS_W-1:0] pos,
                                       input logic [grw_pkg::CFG_W-1:0] lim);
        logic ok_lo;
        logic ok_hi;
        ok_lo = pos >= -POS_W'((1 << FRAC_W) - 1);
        ok_hi = pos[POS_W-1] ? (lim != '0)
              : (pos[POS_W-1:FRAC_W] < (POS_W-FRAC_W)'(lim));
        return ok_lo && ok_hi;
    endfunction

    always_comb
    begin
        wlim = (map_width > grw_pkg::CFG_W'(MAP_SIZE)) ? grw_pkg::CFG_W'(MAP_SIZE) : map_width;
        hlim = (map_height > grw_pkg::CFG_W'(MAP_SIZE)) ? grw_pkg::CFG_W'(MAP_SIZE) : map_height;
        px = in_reg.cast_axis ? c_reg : s_reg;
        py = in_reg.cast_axis ? s_reg : c_reg;
        in_x = inside_of(px, wlim);
        in_y = inside_of(py, hlim);
        ci = px[POS_W-1] ? '0 : px[FRAC_W +: IDX_W];
        ri = py[POS_W-1] ? '0 : py[FRAC_W +: IDX_W];
    end

    // Map store access
    logic [MAP_SIZE-1:0] rd_data;
    logic [MAP_SIZE-1:0] wr_row;
    logic [IDX_W-1:0]    rd_addr;

    always_comb
    begin
        rd_addr = cmd.lookup ? ri : in_reg.cell_row[IDX_W-1:0];
        wr_row  = rd_data;
        wr_row[in_reg.cell_col[IDX_W-1:0]] = in_reg.cell_is_wall;
    end

    grw_map_mem #(
        .MAP_SIZE (MAP_SIZE)
    ) u_map_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (cmd.lookup | cmd.wr_read),
        .rd_addr (rd_addr),
        .wr_en   (cmd.wr_write),
        .wr_addr (in_reg.cell_row[IDX_W-1:0]),
        .wr_data (wr_row),
        .rd_data (rd_data)
    );

    // Control-free payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            in_reg <= in_word;
        if (cmd.prep)
        begin
            degen_reg <= (ds == '0);
            up_reg    <= ts > os;
            neg_reg   <= dc[grw_pkg::DELTA_W-1] ^ ds[grw_pkg::DELTA_W-1];
            den_reg   <= ds_mag;
            num_reg   <= {dc_mag, {FRAC_W{1'b0}}};
            rem_reg   <= '0;
            dcnt_reg  <= '0;
            ps_reg    <= ps_new;
            ofs_reg   <= ofs_full[grw_pkg::OFS_W-1:0];
            wall_reg  <= 1'b0;
        end
        if (cmd.div_step)
        begin
            rem_reg  <= qbit ? trial - {1'b0, den_reg} : trial;
            num_reg  <= {num_reg[grw_pkg::NUM_W-2:0], qbit};
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        if (cmd.slope_fix)
            slope_reg <= neg_reg ? -signed'(mag_sat) : signed'(mag_sat);
        if (cmd.mul)
            prod_reg <= ofs_reg * slope_reg;
        if (cmd.init)
        begin
            s_reg     <= POS_W'(ps_reg);
            c_reg     <= POS_W'(pq) + POS_W'(oc);
            guard_reg <= '0;
        end
        if (cmd.lookup)
            ci_reg <= ci;
        if (cmd.step)
        begin
            s_reg     <= up_reg ? s_reg + POS_W'(1 << FRAC_W) : s_reg - POS_W'(1 << FRAC_W);
            c_reg     <= up_reg ? s_reg - s_reg + c_reg + POS_W'(slope_reg)
                                : c_reg - POS_W'(slope_reg);
            guard_reg <= guard_reg + 1'b1;
        end
        if (cmd.wall_set)
            wall_reg <= 1'b1;
        if (cmd.out_load)
        begin
            out_reg.hit_x      <= degen_reg ? in_reg.origin_x : grw_pkg::sat24(px);
            out_reg.hit_y      <= degen_reg ? in_reg.origin_y : grw_pkg::sat24(py);
            out_reg.hit_wall   <= wall_reg & ~degen_reg;
            out_reg.degenerate <= degen_reg;
        end
    end

    // Status to controller
    always_comb
    begin
        stat.is_write  = (in_reg.cmd == grw_pkg::CMD_WRITE);
        stat.wr_ok     = (7'(in_reg.cell_col) < 7'(MAP_SIZE)) &&
                         (7'(in_reg.cell_row) < 7'(MAP_SIZE));
        stat.degen     = degen_reg;
        stat.div_last  = (dcnt_reg == DCNT_W'(grw_pkg::NUM_W - 1));
        stat.guard_end = (guard_reg == GUARD_W'(GUARD_N));
        stat.in_map    = in_x && in_y;
        stat.wall_bit  = rd_data[ci_reg];
    end

    assign out_word = out_reg;

endmodule

>>> hdl/grw_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences decode, divide, multiply and the step loop; owns output valid.
// Depends on grw_pkg.
module grw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  grw_pkg::grw_stat_t  stat,
    output grw_pkg::grw_cmd_t   cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CHKDEG,
        ST_DIV,
        ST_SLOPE,
        ST_MUL,
        ST_INIT,
        ST_CHECK,
        ST_LOOK,
        ST_FINISH,
        ST_WR_RD,
        ST_WR_WR
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.is_write)
                    state_next = stat.wr_ok ? ST_WR_RD : ST_IDLE;
                else
                begin
                    cmd.prep   = 1'b1;
                    state_next = ST_CHKDEG;
                end
            end
            ST_CHKDEG:
                state_next = stat.degen ? ST_FINISH : ST_DIV;
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = ST_SLOPE;
            end
            ST_SLOPE:
            begin
                cmd.slope_fix = 1'b1;
                state_next    = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_INIT;
            end
            ST_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (stat.guard_end || !stat.in_map)
                    state_next = ST_FINISH;
                else
                begin
                    cmd.lookup = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (stat.wall_bit)
                begin
                    cmd.wall_set = 1'b1;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_WR_RD:
            begin
                cmd.wr_read = 1'b1;
                state_next  = ST_WR_WR;
            end
            ST_WR_WR:
            begin
                cmd.wr_write = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hdl/grid_ray_wall_cast_top.sv
`timescale 1ns / 1ps
// Grid ray wall cast: top level with register port, controller and datapath.
// Depends on grw_pkg, grw_ctrl, grw_datapath (and grw_map_mem below it).
//
// Usage: in_word arrives on in_valid/in_stall. A write word (cmd 0) sets or
// clears one wall map cell and gives no result; it reads the cell's map
// row and writes it back. A cast word (cmd 1) gives one out_word on
// out_valid/out_stall. A cast whose denominator is zero goes straight to
// its result; otherwise it runs a bit-serial slope divider, one multiply,
// then a bounds check and a registered map row read for each cell stepped
// (at most MAP_SIZE + 2). One word is in work at a time; in_stall is high
// from acceptance until the block returns to idle. The finished word sits
// in an output register, so a new word is taken while a result still
// waits; a stalled receiver holds the block only when the next result is
// ready and the register is still full. Reset clears the wall map (per-row
// valid bits, at once), sets map_width and map_height to 64 and drops
// out_valid. Registers sit at 0 and 4 on the APB-style port; the user must
// write them only while the block is idle; the block does not enforce it.
module grid_ray_wall_cast_top #(
    parameter int MAP_SIZE = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  grw_pkg::in_word_t    in_word,
    output logic                 out_valid,
    input  logic                 out_stall,
    output grw_pkg::out_word_t   out_word,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [grw_pkg::CFG_W-1:0] map_width_reg;
    logic [grw_pkg::CFG_W-1:0] map_height_reg;
    logic                      cfg_wr;
    grw_pkg::grw_cmd_t         cmd;
    grw_pkg::grw_stat_t        stat;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[2] ? {25'b0, map_height_reg} : {25'b0, map_width_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= 7'd64;
            map_height_reg <= 7'd64;
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
                map_height_reg <= pwdata[grw_pkg::CFG_W-1:0];
            else
                map_width_reg <= pwdata[grw_pkg::CFG_W-1:0];
        end
    end

    grw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    grw_datapath #(
        .MAP_SIZE (MAP_SIZE)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_word    (in_word),
        .map_width  (map_width_reg),
        .map_height (map_height_reg),
        .out_word   (out_word)
    );

    // Checks
    a_degen_no_wall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.degenerate |-> !out_word.hit_wall)
        else $error("degenerate result reports a wall hit");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("block not busy after taking a word");

    a_width_write: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && !paddr[2] |=> map_width_reg == $past(pwdata[6:0]))
        else $error("map_width write lost");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for grid_ray_wall_cast_top: random and directed
// cell writes and ray casts, checked against an in-bench ray stepper.
// Depends on grw_pkg and the grid_ray_wall_cast_top RTL.
module tb_top;

    localparam int  GRID    = 64;
    localparam int  ONE     = 65536;
    localparam int  SETTLE  = 250;   // longest cast plus margin, in cycles

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid;
    logic                in_stall;
    grw_pkg::in_word_t   in_word;
    logic                out_valid;
    logic                out_stall;
    grw_pkg::out_word_t  out_word;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // predictor state
    bit [GRID-1:0] wall_rows [GRID];
    bit [6:0]      width_reg;
    bit [6:0]      height_reg;

    grw_pkg::in_word_t  word_queue[$];
    grw_pkg::out_word_t pending_hits[$];
    int        errors = 0;
    bit        no_idle = 1'b0;
    int        hold_request = 0;
    int        hold_left;
    int        in_gap;
    int        out_gap;

    grid_ray_wall_cast_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [grw_pkg::COORD_W-1:0] clamp24(longint v);
        if (v > 8388607)
            v = 8388607;
        if (v < -8388608)
            v = -8388608;
        return v[grw_pkg::COORD_W-1:0];
    endfunction

    // cell index of a position, -1 when outside [0, lim)
    function automatic int cell_of(longint pos, longint lim);
        longint q;
        q = pos / ONE;
        if (q < 0 || q >= lim)
            return -1;
        return int'(q);
    endfunction

    // Expected stop point of one cast with the current map and sizes
    function automatic grw_pkg::out_word_t predict_stop(grw_pkg::in_word_t w);
        longint ox, oy, tx, ty, os, oc, ts, ds, dc;
        longint slope, step_s, step_c, ps, s, c, x, y, wl, hl;
        int ci, ri;
        bit wall;
        grw_pkg::out_word_t r;
        ox = w.origin_x;
        oy = w.origin_y;
        tx = w.target_x;
        ty = w.target_y;
        wall = 1'b0;
        if (w.cast_axis)
        begin
            os = oy; oc = ox; ts = ty; ds = ty - oy; dc = tx - ox;
        end
        else
        begin
            os = ox; oc = oy; ts = tx; ds = tx - ox; dc = ty - oy;
        end
        if (ds == 0)
        begin
            r.hit_x = clamp24(ox);
            r.hit_y = clamp24(oy);
            r.hit_wall = 1'b0;
            r.degenerate = 1'b1;
            return r;
        end
        slope = (dc * ONE) / ds;
        if (slope > 64'sd2147483647)
            slope = 64'sd2147483647;
        if (slope < -64'sd2147483647)
            slope = -64'sd2147483647;
        // snap to the first grid line ahead
        if (ts > os)
        begin
            ps = os - (os & 64'hFFFF) + ONE;
            step_s = ONE;
            step_c = slope;
        end
        else
        begin
            ps = os - (os & 64'hFFFF) - grw_pkg::EPS_LSB;
            step_s = -ONE;
            step_c = -slope;
        end
        c = ((ps - os) * slope) / ONE + oc;
        s = ps;
        wl = (width_reg > GRID) ? GRID : width_reg;
        hl = (height_reg > GRID) ? GRID : height_reg;
        for (int g = 0; g < GRID + 2; g++)
        begin
            x = w.cast_axis ? c : s;
            y = w.cast_axis ? s : c;
            ci = cell_of(x, wl);
            ri = cell_of(y, hl);
            if (ci < 0 || ri < 0)
                break;
            if (wall_rows[ri][ci])
            begin
                wall = 1'b1;
                break;
            end
            s += step_s;
            c += step_c;
        end
        x = w.cast_axis ? c : s;
        y = w.cast_axis ? s : c;
        r.hit_x = clamp24(x);
        r.hit_y = clamp24(y);
        r.hit_wall = wall;
        r.degenerate = 1'b0;
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Sender: one word at a time, random gap after each
    always @(posedge clk or negedge rst_n)
    begin
        bit fire;
        bit nv;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_word  <= '0;
            in_gap   <= 0;
        end
        else
        begin
            fire = in_valid && !in_stall;
            if (fire)
            begin
                if (in_word.cmd == grw_pkg::CMD_CAST)
                    pending_hits.push_back(predict_stop(in_word));
                else if (in_word.cell_is_wall)
                    wall_rows[in_word.cell_row][in_word.cell_col] = 1'b1;
                else
                    wall_rows[in_word.cell_row][in_word.cell_col] = 1'b0;
            end
            if (!in_valid || fire)
            begin
                nv = 1'b0;
                if (in_gap > 0)
                    in_gap <= in_gap - 1;
                else if (word_queue.size() > 0)
                begin
                    in_word <= word_queue.pop_front();
                    nv = 1'b1;
                    in_gap <= no_idle ? 0 : $urandom_range(0, 15);
                end
                in_valid <= nv;
            end
        end
    end

    // Long receiver hold-off, counted on its own
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_request > 0)
        begin
            hold_left <= hold_request;
            hold_request = 0;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Receiver: check each word, random stall between words
    always @(posedge clk or negedge rst_n)
    begin
        grw_pkg::out_word_t want;
        int gap;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap   <= 0;
        end
        else
        begin
            gap = out_gap;
            if (out_valid && !out_stall)
            begin
                if (pending_hits.size() == 0)
                    report("unexpected result word", out_word.hit_x, 0);
                else
                begin
                    want = pending_hits.pop_front();
                    if (out_word.hit_x !== want.hit_x)
                        report("hit_x", out_word.hit_x, want.hit_x);
                    if (out_word.hit_y !== want.hit_y)
                        report("hit_y", out_word.hit_y, want.hit_y);
                    if (out_word.hit_wall !== want.hit_wall)
                        report("hit_wall", out_word.hit_wall, want.hit_wall);
                    if (out_word.degenerate !== want.degenerate)
                        report("degenerate", out_word.degenerate, want.degenerate);
                end
                gap = no_idle ? 0 : $urandom_range(0, 15);
            end
            else if (gap > 0)
                gap--;
            out_gap   <= gap;
            out_stall <= (hold_left > 0) || (gap > 0);
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == 3'd0)
            width_reg = data[6:0];
        else if (addr == 3'd4)
            height_reg = data[6:0];
    endtask

    function automatic grw_pkg::in_word_t cell_word(int col, int row, bit wall);
        grw_pkg::in_word_t w;
        w = '0;
        w.cmd = grw_pkg::CMD_WRITE;
        w.cell_col = col[grw_pkg::CELL_W-1:0];
        w.cell_row = row[grw_pkg::CELL_W-1:0];
        w.cell_is_wall = wall;
        w.origin_x = grw_pkg::COORD_W'($urandom());
        w.target_y = grw_pkg::COORD_W'($urandom());
        return w;
    endfunction

    function automatic grw_pkg::in_word_t cast_word(bit axis, int ox, int oy, int tx, int ty);
        grw_pkg::in_word_t w;
        w = '0;
        w.cmd = grw_pkg::CMD_CAST;
        w.cast_axis = axis;
        w.origin_x = ox[grw_pkg::COORD_W-1:0];
        w.origin_y = oy[grw_pkg::COORD_W-1:0];
        w.target_x = tx[grw_pkg::COORD_W-1:0];
        w.target_y = ty[grw_pkg::COORD_W-1:0];
        w.cell_col = grw_pkg::CELL_W'($urandom());
        w.cell_row = grw_pkg::CELL_W'($urandom());
        w.cell_is_wall = 1'($urandom());
        return w;
    endfunction

    // Mostly in-map rays and wall edits, some raw noise
    function automatic grw_pkg::in_word_t random_word();
        int kind, ox, oy, tx, ty;
        logic [127:0] raw;
        kind = $urandom_range(0, 19);
        if (kind == 0)
        begin
            raw = {$urandom(), $urandom(), $urandom(), $urandom()};
            return grw_pkg::in_word_t'(raw[$bits(grw_pkg::in_word_t)-1:0]);
        end
        if (kind < 7)
            return cell_word($urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(0, 9) < 4);
        ox = int'($urandom_range(0, GRID * ONE)) - ONE / 2;
        oy = int'($urandom_range(0, GRID * ONE)) - ONE / 2;
        tx = ox + int'($urandom_range(0, 1 << 20)) - (1 << 19);
        ty = oy + int'($urandom_range(0, 1 << 20)) - (1 << 19);
        if (kind == 7)
            tx = ox;
        else if (kind == 8)
            ty = oy;
        else if (kind == 9)
            tx = ox + int'($urandom_range(0, 2)) - 1;
        return cast_word(1'($urandom()), ox, oy, tx, ty);
    endfunction

    task automatic drain();
        while (word_queue.size() > 0 || in_valid || pending_hits.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Stimulus: directed casts, then random phases over map sizes
    initial
    begin
        int widths [7];
        int heights [7];
        widths  = '{64, 1, 127, 0, 20, 64, 33};
        heights = '{64, 1, 127, 64, 37, 0, 64};
        for (int r = 0; r < GRID; r++)
            wall_rows[r] = '0;
        width_reg  = 7'd64;
        height_reg = 7'd64;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, both axes, degenerate, outside start, walls
        word_queue.push_back(cell_word(10, 5, 1'b1));
        word_queue.push_back(cell_word(63, 63, 1'b1));
        word_queue.push_back(cell_word(0, 0, 1'b1));
        word_queue.push_back(cast_word(1'b0, 2 * ONE + 100, 5 * ONE + 9, 20 * ONE, 5 * ONE + 9));
        word_queue.push_back(cast_word(1'b1, 10 * ONE + 5, 20 * ONE, 10 * ONE + 5, 0));
        word_queue.push_back(cast_word(1'b0, 3 * ONE, 3 * ONE, 3 * ONE, 9 * ONE));
        word_queue.push_back(cast_word(1'b1, 3 * ONE, 3 * ONE, 9 * ONE, 3 * ONE));
        word_queue.push_back(cast_word(1'b0, 8388607, 8388607, -8388608, -8388608));
        word_queue.push_back(cast_word(1'b1, -8388608, -8388608, 8388607, 8388607));
        word_queue.push_back(cast_word(1'b0, -8388608, 8388607, 8388607, -8388608));
        word_queue.push_back(cast_word(1'b1, 8388607, 0, 0, 8388607));
        word_queue.push_back(cast_word(1'b0, -1, -1, -ONE * 3, -2));
        word_queue.push_back(cast_word(1'b1, -1, -1, 5, -ONE * 3));
        word_queue.push_back(cast_word(1'b0, 62 * ONE + 7, 62 * ONE, 70 * ONE, 70 * ONE));
        word_queue.push_back(cast_word(1'b0, 5 * ONE, 5 * ONE, 5 * ONE + 1, 60 * ONE));
        word_queue.push_back(cast_word(1'b1, 30 * ONE, 30 * ONE, 31 * ONE, 30 * ONE - 1));
        word_queue.push_back(cell_word(10, 5, 1'b0));
        word_queue.push_back(cast_word(1'b0, 2 * ONE + 100, 5 * ONE + 9, 20 * ONE, 5 * ONE + 9));
        word_queue.push_back(cast_word(1'b0, 1 * ONE + 3, 0, -4 * ONE, 0));
        word_queue.push_back(cell_word(0, 0, 1'b0));
        drain();

        for (int p = 0; p < 7; p++)
        begin
            reg_write(3'd0, widths[p]);
            reg_write(3'd4, heights[p]);
            no_idle = (p == 4);
            if (p == 1)
                hold_request = 400;
            for (int i = 0; i < 95; i++)
                word_queue.push_back(random_word());
            drain();
        end

        if (errors == 0)
            $display("grid_ray_wall_cast_top verification clean");
        else
            $display("grid_ray_wall_cast_top verification failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("grid_ray_wall_cast_top verification failed");
        $finish;
    end

endmodule
